>>> src/accel_tilt_angle_filter_defines.svh
// Assertion macros shared by the checker
`ifndef ACCEL_TILT_ANGLE_FILTER_DEFINES_SVH
`define ACCEL_TILT_ANGLE_FILTER_DEFINES_SVH
`define ATF_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ATF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`endif

>>> src/atf_pkg.sv
package atf_pkg;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CAL_SAMPLES_DEF = 5;
   localparam int IN_W = 16;
   localparam int OUT_W = 17;
   localparam int ANG_W = 18;
   localparam int GAIN_W = 9;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd128;
   // CORDIC vectors: 256 * up to 46341 plus growth
   localparam int CV_W = 28;
   localparam int ACC_W = 26;
   localparam int SQ_W = 32;
   localparam int MAG_W = 17;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_SQRT_R, ST_SQRT_P, ST_CORDIC_R, ST_CORDIC_P,
      ST_BLEND_MUL, ST_BLEND_SUM, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic sqrt_r_init;
      logic sqrt_p_init;
      logic sqrt_step;
      logic cordic_r_init;
      logic cordic_p_init;
      logic cordic_step;
      logic blend_mul;
      logic blend_sum;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic cordic_done;
   } status_type;

   function automatic logic signed [ACC_W-1:0] atan_q16(input logic [4:0] i);
      unique case (i)
         5'd0: atan_q16 = 26'sd2949120; 5'd1: atan_q16 = 26'sd1740967;
         5'd2: atan_q16 = 26'sd919879;  5'd3: atan_q16 = 26'sd466945;
         5'd4: atan_q16 = 26'sd234379;  5'd5: atan_q16 = 26'sd117304;
         5'd6: atan_q16 = 26'sd58666;   5'd7: atan_q16 = 26'sd29335;
         5'd8: atan_q16 = 26'sd14668;   5'd9: atan_q16 = 26'sd7334;
         5'd10: atan_q16 = 26'sd3667;   5'd11: atan_q16 = 26'sd1833;
         5'd12: atan_q16 = 26'sd917;    5'd13: atan_q16 = 26'sd458;
         5'd14: atan_q16 = 26'sd229;    5'd15: atan_q16 = 26'sd115;
         5'd16: atan_q16 = 26'sd57;     5'd17: atan_q16 = 26'sd29;
         5'd18: atan_q16 = 26'sd14;     5'd19: atan_q16 = 26'sd7;
         5'd20: atan_q16 = 26'sd4;      5'd21: atan_q16 = 26'sd2;
         5'd22: atan_q16 = 26'sd1;
         default: atan_q16 = 26'sd0;
      endcase
   endfunction
endpackage

>>> src/atf_if.sv
interface atf_req_if;
   import atf_pkg::*;
   logic valid;
   logic ready;
   logic signed [IN_W-1:0] accel_x;
   logic signed [IN_W-1:0] accel_y;
   logic signed [IN_W-1:0] accel_z;
   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atf_rsp_if;
   import atf_pkg::*;
   logic valid;
   logic ready;
   logic signed [OUT_W-1:0] roll_angle;
   logic signed [OUT_W-1:0] pitch_angle;
   modport source (output valid, roll_angle, pitch_angle, input ready);
   modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface atf_csr_if;
   import atf_pkg::*;
   logic valid;
   logic ready;
   logic [GAIN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> src/atf_ctrl.sv
module atf_ctrl
   import atf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic       rsp_fire,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_ready,
   output logic       rsp_valid
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            cmd.sqrt_r_init = 1'b1;
            state_in = ST_SQRT_R;
         end
         ST_SQRT_R: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_done) begin
               cmd.sqrt_step = 1'b0;
               cmd.sqrt_p_init = 1'b1;
               state_in = ST_SQRT_P;
            end
         end
         ST_SQRT_P: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_done) begin
               cmd.sqrt_step = 1'b0;
               cmd.cordic_r_init = 1'b1;
               state_in = ST_CORDIC_R;
            end
         end
         ST_CORDIC_R: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_done) begin
               cmd.cordic_step = 1'b0;
               cmd.cordic_p_init = 1'b1;
               state_in = ST_CORDIC_P;
            end
         end
         ST_CORDIC_P: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_done) begin
               cmd.cordic_step = 1'b0;
               cmd.blend_mul = 1'b1;
               state_in = ST_BLEND_MUL;
            end
         end
         ST_BLEND_MUL: begin
            cmd.blend_sum = 1'b1;
            state_in = ST_BLEND_SUM;
         end
         ST_BLEND_SUM: state_in = ST_OUT;
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> src/atf_datapath.sv
module atf_datapath
   import atf_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int CAL_SAMPLES  = CAL_SAMPLES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic signed [IN_W-1:0]  accel_x,
   input  logic signed [IN_W-1:0]  accel_y,
   input  logic signed [IN_W-1:0]  accel_z,
   input  logic [GAIN_W-1:0]       gain,
   output logic signed [OUT_W-1:0] roll_angle,
   output logic signed [OUT_W-1:0] pitch_angle
);
   localparam int SQ_STEPS = SQ_W / 2;
   localparam int SC_W = $clog2(SQ_STEPS + 1);
   localparam int CS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int CC_W = $clog2(CS + 1);
   localparam int SMP_W = 3;
   localparam int PR_W = ANG_W + GAIN_W + 2;

   logic signed [IN_W:0] x_ff, y_ff, z_ff;
   logic [SQ_W-1:0] ysq_ff, zsq_ff;
   logic [SQ_W:0] rem_ff, rem_in;
   logic [SQ_W-1:0] res_ff, res_in, bit_ff, bit_in;
   logic [SC_W-1:0] sq_cnt_ff;
   logic [MAG_W-1:0] mag_r_ff, mag_p_ff;
   logic signed [CV_W-1:0] cx_ff, cy_ff;
   logic signed [ACC_W-1:0] ang_ff;
   logic [CC_W-1:0] cc_ff;
   logic zero_ff;
   logic signed [ANG_W-1:0] roll_ff;
   logic signed [ANG_W-1:0] roll_off_ff, pitch_off_ff, last_r_ff, last_p_ff;
   logic signed [ANG_W-1:0] cur_r_ff, cur_p_ff;
   logic [SMP_W-1:0] count_ff;
   logic signed [PR_W-1:0] pr_a_ff, pr_b_ff, pp_a_ff, pp_b_ff;
   logic signed [OUT_W-1:0] out_r_ff, out_p_ff;

   // square root, one result bit a step
   logic [SQ_W:0] trial;
   always_comb begin
      trial = {1'b0, res_ff} + {1'b0, bit_ff};
      rem_in = rem_ff;
      res_in = res_ff >> 1;
      if (rem_ff >= trial) begin
         rem_in = rem_ff - trial;
         res_in = (res_ff >> 1) + bit_ff;
      end
      bit_in = bit_ff >> 2;
   end
   assign status.sqrt_done = (sq_cnt_ff == SC_W'(SQ_STEPS));

   // CORDIC vectoring step
   logic signed [CV_W-1:0] xs, ys;
   logic [4:0] ci;
   assign ci = 5'(cc_ff);
   assign xs = cx_ff >>> cc_ff;
   assign ys = cy_ff >>> cc_ff;
   assign status.cordic_done = (cc_ff == CC_W'(CS));

   logic signed [ANG_W-1:0] ang_rnd;
   assign ang_rnd = zero_ff ? '0 : ANG_W'((ang_ff + ACC_W'(128)) >>> 8);

   logic [GAIN_W-1:0] a_sat;
   assign a_sat = (gain > GAIN_ONE) ? GAIN_ONE : gain;
   logic signed [ANG_W-1:0] cur_r, cur_p;
   logic cal;
   assign cal = (count_ff < SMP_W'(CAL_SAMPLES));
   assign cur_r = cal ? '0 : roll_ff - roll_off_ff;
   assign cur_p = cal ? '0 : ang_rnd - pitch_off_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= (IN_W+1)'(accel_x);
         y_ff <= (IN_W+1)'(accel_y);
         z_ff <= (IN_W+1)'(accel_z);
      end
      if (cmd.square) begin
         ysq_ff <= SQ_W'(y_ff) * SQ_W'(y_ff);
         zsq_ff <= SQ_W'(z_ff) * SQ_W'(z_ff);
      end
      if (cmd.sqrt_r_init || cmd.sqrt_p_init) begin
         if (cmd.sqrt_r_init) rem_ff <= {1'b0, SQ_W'(x_ff) * SQ_W'(x_ff)}
                                       + {1'b0, SQ_W'(z_ff) * SQ_W'(z_ff)};
         else rem_ff <= {1'b0, ysq_ff} + {1'b0, zsq_ff};
         res_ff <= '0;
         bit_ff <= SQ_W'(1) << (SQ_W - 2);
         sq_cnt_ff <= '0;
         if (cmd.sqrt_p_init) mag_r_ff <= MAG_W'(res_ff);
      end else if (cmd.sqrt_step) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_in;
         sq_cnt_ff <= sq_cnt_ff + SC_W'(1);
      end
      if (cmd.cordic_r_init) mag_p_ff <= MAG_W'(res_ff);
      if (cmd.cordic_r_init || cmd.cordic_p_init) begin
         if (cmd.cordic_r_init) begin
            cx_ff <= CV_W'(mag_r_ff) <<< 8;
            cy_ff <= CV_W'(y_ff) <<< 8;
            zero_ff <= (mag_r_ff == '0) && (y_ff == '0);
         end else begin
            cx_ff <= CV_W'(mag_p_ff) <<< 8;
            cy_ff <= CV_W'(-x_ff) <<< 8;
            zero_ff <= (mag_p_ff == '0) && (x_ff == '0);
            roll_ff <= ang_rnd;
         end
         ang_ff <= '0;
         cc_ff <= '0;
      end else if (cmd.cordic_step) begin
         if (cy_ff < 0) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            ang_ff <= ang_ff - atan_q16(ci);
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            ang_ff <= ang_ff + atan_q16(ci);
         end
         cc_ff <= cc_ff + CC_W'(1);
      end
      if (cmd.blend_mul) begin
         cur_r_ff <= cur_r;
         cur_p_ff <= cur_p;
         pr_a_ff <= PR_W'(cur_r) * PR_W'($signed({1'b0, a_sat}));
         pr_b_ff <= PR_W'(last_r_ff) * PR_W'($signed({1'b0, GAIN_ONE - a_sat}));
         pp_a_ff <= PR_W'(cur_p) * PR_W'($signed({1'b0, a_sat}));
         pp_b_ff <= PR_W'(last_p_ff) * PR_W'($signed({1'b0, GAIN_ONE - a_sat}));
      end
      if (cmd.blend_sum) begin
         out_r_ff <= OUT_W'((pr_a_ff + pr_b_ff + PR_W'(128)) >>> 8);
         out_p_ff <= OUT_W'((pp_a_ff + pp_b_ff + PR_W'(128)) >>> 8);
      end
   end

   // calibration and history state
   always_ff @(posedge clock) begin
      if (reset) begin
         roll_off_ff <= '0;
         pitch_off_ff <= '0;
         last_r_ff <= '0;
         last_p_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.blend_mul && cal) begin
            roll_off_ff <= roll_ff;
            pitch_off_ff <= ang_rnd;
            count_ff <= count_ff + SMP_W'(1);
         end
         if (cmd.blend_sum) begin
            last_r_ff <= cur_r_ff;
            last_p_ff <= cur_p_ff;
         end
      end
   end

   assign roll_angle = out_r_ff;
   assign pitch_angle = out_p_ff;
endmodule

>>> src/accel_tilt_angle_filter.sv
// Channel   Dir  Payload
// req       in   accel_x, accel_y, accel_z (signed 16)
// rsp       out  roll_angle, pitch_angle (signed Q9.8, 17)
// csr       in   filter_gain (9 bits)
// One sample at a time: each sample runs the two 16-step square roots and two
// CORDIC passes on one shared datapath.
// Reset is synchronous; it clears offsets, history, count and gain to 128.
// A stalled response holds; no new sample is taken until it is delivered.
module accel_tilt_angle_filter
   import atf_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int CAL_SAMPLES  = CAL_SAMPLES_DEF
) (
   input logic       clock,
   input logic       reset,
   atf_req_if.sink   req,
   atf_rsp_if.source rsp,
   atf_csr_if.sink   csr
);
   cmd_type cmd;
   status_type status;
   logic [GAIN_W-1:0] gain_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) gain_ff <= GAIN_RESET;
      else if (csr.valid) gain_ff <= csr.data;
   end

   atf_ctrl u_ctrl (
      .clock, .reset,
      .req_fire (req.valid && req.ready),
      .rsp_fire (rsp.valid && rsp.ready),
      .status, .cmd,
      .req_ready (req.ready),
      .rsp_valid (rsp.valid)
   );

   atf_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .CAL_SAMPLES(CAL_SAMPLES)) u_dp (
      .clock, .reset, .cmd, .status,
      .accel_x (req.accel_x), .accel_y (req.accel_y), .accel_z (req.accel_z),
      .gain (gain_ff),
      .roll_angle (rsp.roll_angle), .pitch_angle (rsp.pitch_angle)
   );
endmodule

>>> src/atf_checker.sv
`include "accel_tilt_angle_filter_defines.svh"
module atf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [16:0] rsp_roll,
   input logic [16:0] rsp_pitch
);
   // one transaction in flight: never ready while a response is pending
   `ATF_ASSERT_IMPL(a_excl, clock, reset, !(rsp_valid && req_ready))
   // accepted request produces no response on the next cycle
   `ATF_ASSERT_IMPL(a_latency, clock, reset, (req_valid && req_ready) |=> !rsp_valid)
   `ATF_ASSERT_IMPL(a_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_roll) && $stable(rsp_pitch)))
   `ATF_ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_valid)
endmodule

bind accel_tilt_angle_filter atf_checker u_atf_checker (
   .clock (clock), .reset (reset),
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_roll (rsp.roll_angle), .rsp_pitch (rsp.pitch_angle)
);
